// ----- rtl/mie_pkg.sv -----
// Shared constants and types for the modular inverse block.
// No dependencies; imported by mie_round and the top level.
`default_nettype none
package mie_pkg;

  localparam int WIDTH = 16;
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(26);

  // request from the sequencer to the round engine
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
    logic [WIDTH-1:0] coef;
    logic [WIDTH-1:0] modulus;
  } rnd_req_t;

  // round engine status back to the sequencer
  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] prod;
  } rnd_res_t;

endpackage
`default_nettype wire

// ----- rtl/mie_round.sv -----
// One Euclid round: bit-serial restoring division, one quotient bit per cycle,
// with the product quotient*coef mod modulus built by Horner. Depends on mie_pkg.
`default_nettype none
module mie_round import mie_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rnd_req_t req,
  output rnd_res_t      res
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WIDTH-1:0] dvd_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] prod_r;

  logic [WIDTH:0]   sh;
  logic             qbit;
  logic [WIDTH:0]   rem_diff;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH:0]   p2;
  logic [WIDTH:0]   p2m;
  logic [WIDTH:0]   pa;
  logic [WIDTH-1:0] prod_nxt;

  always_comb begin
    sh       = {rem_r, dvd_r[WIDTH-1]};
    qbit     = (sh >= {1'b0, req.divisor});
    rem_diff = sh - {1'b0, req.divisor};
    rem_nxt  = qbit ? rem_diff[WIDTH-1:0] : sh[WIDTH-1:0];
    // double, reduce, add coef on a one bit, reduce again
    p2       = {prod_r, 1'b0};
    p2m      = (p2 >= {1'b0, req.modulus}) ? (p2 - {1'b0, req.modulus}) : p2;
    pa       = p2m + (qbit ? {1'b0, req.coef} : '0);
    prod_nxt = (pa >= {1'b0, req.modulus}) ? WIDTH'(pa - {1'b0, req.modulus})
                                           : pa[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WIDTH-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r  <= req.dividend;
      rem_r  <= '0;
      prod_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[WIDTH-2:0], 1'b0};
      rem_r  <= rem_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;
  assign res.prod = prod_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < req.divisor)
    else $error("round remainder not below divisor");

  a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && req.modulus != '0 |-> prod_r < req.modulus)
    else $error("round product not reduced");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("round done held more than one cycle");

endmodule
`default_nettype wire

// ----- rtl/modular_inverse_extended_euclid_top.sv -----
// Modular inverse by extended Euclid: sequencer, coefficient update, result.
// Depends on mie_pkg and mie_round.
// Each Euclid round is a check state, the bit-serial division in mie_round and a state that
// takes its result; a transaction of k rounds (k <= about 24 at 16 bits) ends in a final
// check that raises the result strobe. busy drops in the strobe cycle, so the next
// transaction can be accepted there; a new one is taken only after the previous result.
// Reset: synchronous active-low rst_n, modulus returns to 26; results cannot be stalled.
`default_nettype none
module modular_inverse_extended_euclid_top import mie_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [WIDTH-1:0] cfg_wdata,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WIDTH-1:0] in_value,
  output logic                  out_valid,
  output logic      [WIDTH-1:0] out_inverse,
  output logic                  out_invertible
);

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_RUN} state_t;

  state_t           state_r;
  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] r_r;
  logic [WIDTH-1:0] nr_r;
  logic [WIDTH-1:0] t_r;
  logic [WIDTH-1:0] nt_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] inverse_r;
  logic             invertible_r;

  rnd_req_t         req;
  rnd_res_t         res;
  logic [WIDTH:0]   t_wrap;
  logic [WIDTH-1:0] t_nxt;

  always_comb begin
    req.start    = (state_r == ST_CHECK) && (nr_r != '0);
    req.dividend = r_r;
    req.divisor  = nr_r;
    req.coef     = nt_r;
    req.modulus  = modulus_r;
    // t - prod mod m, with one wrap by m when it would go negative
    t_wrap = {1'b0, t_r} + {1'b0, modulus_r} - {1'b0, res.prod};
    t_nxt  = (t_r >= res.prod) ? (t_r - res.prod) : t_wrap[WIDTH-1:0];
  end

  mie_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (nr_r == '0) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (res.done) begin
            state_r <= ST_CHECK;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // zero modulus: force an immediate not-invertible answer
          r_r  <= modulus_r;
          nr_r <= (modulus_r == '0) ? '0 : in_value;
          t_r  <= '0;
          nt_r <= (modulus_r == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
      end
      ST_CHECK: begin
        if (nr_r == '0) begin
          invertible_r <= (r_r == WIDTH'(1));
          inverse_r    <= (r_r == WIDTH'(1)) ? t_r : '0;
        end
      end
      ST_RUN: begin
        if (res.done) begin
          t_r  <= nt_r;
          nt_r <= t_nxt;
          r_r  <= nr_r;
          nr_r <= res.rem;
        end
      end
      default: ;
    endcase
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_inverse    = inverse_r;
  assign out_invertible = invertible_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_zero_when_not_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invertible |-> out_inverse == '0)
    else $error("non-invertible result with nonzero inverse");

  a_inverse_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invertible |-> out_inverse < modulus_r)
    else $error("inverse not reduced by modulus");

  a_coef_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK && modulus_r != '0 |-> t_r < modulus_r && nt_r < modulus_r)
    else $error("coefficient out of range");

endmodule
`default_nettype wire

// ----- bench/inverse_checker.sv -----
// Checker for the modular inverse block: tracks the modulus register, predicts each result
// from the accepted requests and compares it with the result strobe.
// Depends on mie_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 100ps
module inverse_checker import mie_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [WIDTH-1:0] cfg_wdata,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic [WIDTH-1:0] in_value,
  input  wire logic             out_valid,
  input  wire logic [WIDTH-1:0] out_inverse,
  input  wire logic             out_invertible,
  output int                    fail_count,
  output int                    outstanding,
  output int                    checked_count
);

  typedef logic [2*WIDTH-1:0] wide_t;

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic             invertible;
  } inv_result_t;

  inv_result_t      expected_inverses[$];
  logic [WIDTH-1:0] track_modulus;
  int               mismatches = 0;
  int               n_checked = 0;

  // Extended Euclid with coefficients kept reduced modulo the modulus.
  function automatic inv_result_t predict_inverse(logic [WIDTH-1:0] value,
                                                  logic [WIDTH-1:0] modulus);
    wide_t       m, r, nr, t, nt, q, rem, prod, nxt;
    inv_result_t res;
    res = '0;
    if (modulus == '0) return res;
    m  = modulus;
    r  = m;
    nr = value;
    t  = '0;
    nt = (m == 1) ? '0 : wide_t'(1);
    while (nr != 0) begin
      q    = r / nr;
      rem  = r % nr;
      prod = ((q % m) * nt) % m;
      nxt  = (t + m - prod) % m;
      t    = nt;
      nt   = nxt;
      r    = nr;
      nr   = rem;
    end
    if (r == 1) begin
      res.inverse    = WIDTH'(t % m);
      res.invertible = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    inv_result_t want;
    if (!rst_n) begin
      expected_inverses.delete();
      track_modulus = MODULUS_RESET;
    end else begin
      if (out_valid) begin
        if (expected_inverses.size() == 0) begin
          $error("result with no request outstanding: inverse %0d, invertible %0d",
                 out_inverse, out_invertible);
          mismatches++;
        end else begin
          want = expected_inverses.pop_front();
          n_checked++;
          if (out_inverse !== want.inverse) begin
            $error("inverse: expected %0d, got %0d", want.inverse, out_inverse);
            mismatches++;
          end
          if (out_invertible !== want.invertible) begin
            $error("invertible: expected %0d, got %0d", want.invertible, out_invertible);
            mismatches++;
          end
        end
      end
      // predict with the modulus in force before any write at this edge
      if (start && !busy)
        expected_inverses.push_back(predict_inverse(in_value, track_modulus));
      if (cfg_we)
        track_modulus = cfg_wdata;
    end
    outstanding   <= expected_inverses.size();
    fail_count    <= mismatches;
    checked_count <= n_checked;
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the modular inverse testbench: clock, reset, modulus writes and requests.
// Depends on mie_pkg, inverse_checker and modular_inverse_extended_euclid_top.
`timescale 1ns / 100ps
module tb_top;
  import mie_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 3 + 26 * (WIDTH + 2);

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [WIDTH-1:0] cfg_wdata = '0;
  logic             start     = 1'b0;
  logic [WIDTH-1:0] in_value  = '0;
  logic             busy;
  logic             out_valid;
  logic [WIDTH-1:0] out_inverse;
  logic             out_invertible;

  int fail_count;
  int outstanding;
  int checked_count;
  int stall_cycles  = 0;
  int requests_sent = 0;
  int modulus_writes = 0;
  bit idle_on = 1'b1;

  modular_inverse_extended_euclid_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_inverse    (out_inverse),
    .out_invertible (out_invertible)
  );

  inverse_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_inverse    (out_inverse),
    .out_invertible (out_invertible),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $error("no transaction for %0d cycles", stall_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Hold start until the block takes the transaction; start stays high for back-to-back use.
  task automatic send_value(input logic [WIDTH-1:0] v);
    while (idle_on && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic set_modulus(input logic [WIDTH-1:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_writes++;
  endtask

  initial begin
    logic [WIDTH-1:0] m;
    logic [WIDTH-1:0] v;
    logic [WIDTH-1:0] reset_mod_values [10];
    logic [WIDTH-1:0] wide_mod_values [6];

    reset_mod_values = '{16'd0, 16'd1, 16'd25, 16'd26, 16'd27,
                         16'd52, 16'd3, 16'd13, 16'hFFFF, 16'h8000};
    wide_mod_values  = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFE, 16'hFFFF};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset modulus: zero, multiples, values above the modulus
    foreach (reset_mod_values[i]) send_value(reset_mod_values[i]);
    // modulus one: everything invertible with inverse zero
    set_modulus(16'd1);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'hFFFF);
    // zero modulus: never invertible
    set_modulus(16'd0);
    send_value(16'd0);
    send_value(16'd5);
    send_value(16'hFFFF);
    set_modulus(16'hFFFF);
    foreach (wide_mod_values[i]) send_value(wide_mod_values[i]);

    for (int ph = 0; ph < 12; ph++) begin
      // long stretch with no sender idling
      idle_on = (ph < 5 || ph > 6);
      case (ph % 6)
        0:       m = WIDTH'($urandom_range(1, 65535));
        1:       m = WIDTH'($urandom_range(2, 64));
        2:       m = 16'd65521;
        3:       m = (ph == 3) ? 16'hFFFF : 16'd2;
        4:       m = WIDTH'(1 << $urandom_range(1, 15));
        default: m = WIDTH'($urandom_range(1, 65535));
      endcase
      set_modulus(m);
      repeat (125) begin
        case ($urandom_range(0, 9))
          0:       v = $urandom_range(0, 1) ? '0 : '1;
          1:       v = WIDTH'(m * $urandom_range(0, 3));
          2, 3:    v = (m > 1) ? WIDTH'($urandom_range(0, m - 1)) : WIDTH'($urandom);
          default: v = WIDTH'($urandom);
        endcase
        send_value(v);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d inverse requests across %0d modulus writes and the reset modulus;",
             requests_sent, modulus_writes);
    $display("%0d results compared, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
